### src/ildl_pkg.sv
// ----------------------------------------------------------------------------
// ildl_pkg
// Shared types and constants for the interpolating loop delay line.
// ----------------------------------------------------------------------------
package ildl_pkg;

    localparam int DEPTH        = 65536;
    localparam int ADDR_BITS    = $clog2(DEPTH);
    localparam int LEN_BITS     = ADDR_BITS + 1;
    localparam int SAMPLE_BITS  = 24;
    localparam int FRAC_BITS    = 16;
    localparam int DELAY_BITS   = 16;
    localparam int B_BITS       = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int MIN_LEN      = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_BUF_LEN   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INTERP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOOP_EN   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIN_BEGIN = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIN_STOP  = 3'd4;

    // One queued input transaction.
    typedef struct packed {
        logic                          rec;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [DELAY_BITS-1:0]         dw;
        logic [FRAC_BITS-1:0]          df;
    } t_item;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic [LEN_BITS-1:0]  buf_len;
        logic                 interp;
        logic                 loop_en;
        logic [ADDR_BITS-1:0] win_begin;
        logic [ADDR_BITS-1:0] win_stop;
        logic                 head_clr;
    } t_cfg;

    // Status from the back end to the front end.
    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_POS, S_DIV1, S_DIV2,
        S_ADDR, S_READ, S_PREP, S_MUL, S_FIN
    } t_state;

endpackage

### src/ildl_div.sv
// ----------------------------------------------------------------------------
// ildl_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ildl_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ildl_pkg::DELAY_BITS-1:0] i_dividend,
    input  logic [ildl_pkg::LEN_BITS-1:0]   i_divisor,
    output logic                           o_done,
    output logic [ildl_pkg::LEN_BITS-1:0]   o_rem
);
    import ildl_pkg::*;

    localparam int CNT_BITS = $clog2(DELAY_BITS);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [DELAY_BITS-1:0] r_dvd;
    logic [LEN_BITS-1:0]   r_dvs;
    logic [LEN_BITS-1:0]   r_rem;
    logic [LEN_BITS:0]     trial;

    // Shift in the next dividend bit and subtract when it fits.
    assign trial = {r_rem, r_dvd[DELAY_BITS-1]};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_BITS'(DELAY_BITS - 1);
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= {r_dvd[DELAY_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                r_rem <= LEN_BITS'(trial - {1'b0, r_dvs});
            end else begin
                r_rem <= trial[LEN_BITS-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### src/ildl_front.sv
// ----------------------------------------------------------------------------
// ildl_front
// Input side: accepts transactions into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ildl_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_record,
    input  logic signed [ildl_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic [ildl_pkg::DELAY_BITS-1:0]         i_delay_whole,
    input  logic [ildl_pkg::FRAC_BITS-1:0]          i_delay_frac,
    input  ildl_pkg::t_back_stat                    i_stat,
    output logic                                   o_q_valid,
    output ildl_pkg::t_item                         o_q_item,
    input  logic                                   i_q_pop
);
    import ildl_pkg::*;

    t_item      r_q [2];
    logic [1:0] r_count;
    logic       r_rd_ptr;
    logic       r_wr_ptr;
    logic       push;
    logic       pop;

    // No transactions are taken while the store is being cleared.
    assign o_stall = (r_count == 2'd2) || i_stat.clearing;
    assign push    = i_valid && !o_stall;
    assign pop     = i_q_pop && (r_count != 2'd0);

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{rec: i_record, sample: i_sample_in,
                               dw: i_delay_whole, df: i_delay_frac};
        end
    end

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_q[r_rd_ptr];

endmodule

### src/ildl_back.sv
// ----------------------------------------------------------------------------
// ildl_back
// Execution side: sample store, head update, tap addressing and interpolation.
// ----------------------------------------------------------------------------
module ildl_back (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ildl_pkg::t_cfg                           i_cfg,
    input  logic                                    i_q_valid,
    input  ildl_pkg::t_item                          i_q_item,
    output logic                                    o_q_pop,
    output ildl_pkg::t_back_stat                     o_stat,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [ildl_pkg::SAMPLE_BITS-1:0]  o_tap_out
);
    import ildl_pkg::*;

    localparam int PROD_BITS = B_BITS + FRAC_BITS + 1;
    localparam logic signed [B_BITS-1:0] SAT_HI = B_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [B_BITS-1:0] SAT_LO = -SAT_HI - B_BITS'(1);

    t_state                  r_state, n_state;
    t_item                   r_item;
    logic [ADDR_BITS-1:0]    r_head;
    logic                    r_loop_ok;
    logic                    r_use_loop;
    logic [LEN_BITS-1:0]     r_span;
    logic [LEN_BITS-1:0]     r_pos;
    logic [LEN_BITS-1:0]     r_k;
    logic [ADDR_BITS-1:0]    r_a0;
    logic [2:0]              r_cnt;
    logic [1:0]              r_step;
    logic [ADDR_BITS-1:0]    r_clr_addr;
    logic signed [SAMPLE_BITS-1:0] r_x0, r_x1, r_xm1, r_x2, r_rdata;
    logic signed [B_BITS-1:0] r_b, r_c2, r_c1;
    logic                    r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_tap;
    logic [SAMPLE_BITS-1:0]  mem [DEPTH];

    logic                    div_start;
    logic [DELAY_BITS-1:0]   div_dividend;
    logic [LEN_BITS-1:0]     div_divisor;
    logic                    div_done;
    logic [LEN_BITS-1:0]     div_rem;
    logic                    mem_we;
    logic                    mem_re;
    logic [ADDR_BITS-1:0]    mem_addr;
    logic [SAMPLE_BITS-1:0]  mem_wd;
    logic [LEN_BITS-1:0]     len;
    logic [LEN_BITS-1:0]     head_ext;
    logic [LEN_BITS-1:0]     ls_ext;
    logic [LEN_BITS-1:0]     le_ext;
    logic [LEN_BITS-1:0]     a0_ext;
    logic [LEN_BITS-1:0]     next_head;
    logic [LEN_BITS-1:0]     rd_addr;
    logic [LEN_BITS:0]       r0_sum;
    logic [LEN_BITS:0]       a0_sum;
    logic [LEN_BITS-1:0]     a0_plain;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [B_BITS-1:0] rounded;
    logic signed [B_BITS-1:0] addend;
    logic signed [B_BITS-1:0] y_full;
    logic signed [B_BITS-1:0] x0_w, x1_w, xm1_w, x2_w;
    logic                    mul_last;
    logic                    out_free;

    assign len      = i_cfg.buf_len;
    assign head_ext = {1'b0, r_head};
    assign ls_ext   = {1'b0, i_cfg.win_begin};
    assign le_ext   = {1'b0, i_cfg.win_stop};
    assign a0_ext   = {1'b0, r_a0};
    assign out_free = !r_out_valid || !i_stall;
    assign mul_last = i_cfg.interp ? (r_step == 2'd2) : (r_step == 2'd0);

    // Shared remainder unit.
    ildl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Head advance with wrap and loop snap.
    always_comb begin
        next_head = head_ext + 1'b1;
        if (next_head >= len) next_head = '0;
        if (r_loop_ok && next_head == le_ext) next_head = ls_ext;
    end

    // Tap base index from the reduced delay.
    always_comb begin
        if (r_k <= r_pos) begin
            r0_sum = {1'b0, r_pos - r_k};
        end else begin
            r0_sum = {1'b0, r_pos} + {1'b0, r_span} - {1'b0, r_k};
        end
        a0_sum = {1'b0, ls_ext} + r0_sum;
        if (a0_sum >= {1'b0, len}) a0_sum = a0_sum - {1'b0, len};
        if (r_k <= head_ext) begin
            a0_plain = head_ext - r_k;
        end else begin
            a0_plain = head_ext + len - r_k;
        end
    end

    // Stencil addresses in the order x0, x1, xm1, x2.
    always_comb begin
        case (r_cnt)
            3'd0:    rd_addr = a0_ext;
            3'd1:    rd_addr = (r_a0 == '0) ? len - 1'b1 : a0_ext - 1'b1;
            3'd2:    rd_addr = (a0_ext + 1'b1 == len) ? '0 : a0_ext + 1'b1;
            3'd3:    rd_addr = (a0_ext >= LEN_BITS'(2)) ? a0_ext - LEN_BITS'(2)
                                                        : a0_ext + len - LEN_BITS'(2);
            default: rd_addr = a0_ext;
        endcase
    end

    // Polynomial step: rounded product plus the next coefficient.
    always_comb begin
        x0_w  = B_BITS'(r_x0);
        x1_w  = B_BITS'(r_x1);
        xm1_w = B_BITS'(r_xm1);
        x2_w  = B_BITS'(r_x2);
        prod    = PROD_BITS'(r_b) * $signed({1'b0, r_item.df});
        rounded = B_BITS'((prod + PROD_BITS'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
        if (!i_cfg.interp) begin
            addend = x0_w;
        end else begin
            case (r_step)
                2'd0:    addend = r_c2;
                2'd1:    addend = r_c1;
                default: addend = x0_w <<< 1;
            endcase
        end
        y_full = i_cfg.interp ? ((r_b + B_BITS'(1)) >>> 1) : r_b;
    end

    // Sequencer: next state and control strobes.
    always_comb begin
        n_state      = r_state;
        o_q_pop      = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_item.dw;
        div_divisor  = r_use_loop ? r_span : len;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = r_head;
        mem_wd       = r_item.sample;
        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
                mem_wd   = '0;
                if (r_clr_addr == ADDR_BITS'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                mem_we  = r_item.rec;
                n_state = S_POS;
            end
            S_POS: begin
                div_start = 1'b1;
                n_state   = S_DIV1;
            end
            S_DIV1: begin
                if (div_done) begin
                    if (r_use_loop) begin
                        div_start    = 1'b1;
                        div_dividend = r_pos[DELAY_BITS-1:0];
                        div_divisor  = r_span;
                        n_state      = S_DIV2;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_DIV2: begin
                if (div_done) n_state = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_READ;
            end
            S_READ: begin
                mem_re   = (r_cnt != 3'd4);
                mem_addr = rd_addr[ADDR_BITS-1:0];
                if (r_cnt == 3'd4) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (mul_last) n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cfg.head_clr) begin
                r_head <= '0;
            end else if (r_state == S_WRITE) begin
                r_head <= next_head[ADDR_BITS-1:0];
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sample store: one port, registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wd;
        if (mem_re) r_rdata <= $signed(mem[mem_addr]);
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item    <= i_q_item;
                r_loop_ok <= i_cfg.loop_en && (ls_ext < len) && (le_ext <= len);
                if (i_cfg.win_stop >= i_cfg.win_begin) begin
                    r_span <= le_ext - ls_ext;
                end else begin
                    r_span <= len - (ls_ext - le_ext);
                end
            end
            S_WRITE: begin
                r_use_loop <= r_loop_ok && (r_span != '0);
            end
            S_POS: begin
                r_pos      <= (head_ext >= ls_ext) ? head_ext - ls_ext
                                                   : head_ext + len - ls_ext;
            end
            S_DIV1: begin
                if (div_done) r_k <= div_rem;
            end
            S_DIV2: begin
                if (div_done) r_pos <= div_rem;
            end
            S_ADDR: begin
                r_cnt <= '0;
                r_a0  <= r_use_loop ? a0_sum[ADDR_BITS-1:0] : a0_plain[ADDR_BITS-1:0];
            end
            S_READ: begin
                r_cnt <= r_cnt + 1'b1;
                case (r_cnt)
                    3'd1:    r_x0  <= r_rdata;
                    3'd2:    r_x1  <= r_rdata;
                    3'd3:    r_xm1 <= r_rdata;
                    3'd4:    r_x2  <= r_rdata;
                    default: ;
                endcase
            end
            S_PREP: begin
                r_step <= '0;
                if (i_cfg.interp) begin
                    r_b <= x2_w - xm1_w + B_BITS'(3) * (x0_w - x1_w);
                end else begin
                    r_b <= x1_w - x0_w;
                end
                r_c2 <= (xm1_w <<< 1) - B_BITS'(5) * x0_w + (x1_w <<< 2) - x2_w;
                r_c1 <= x1_w - xm1_w;
            end
            S_MUL: begin
                r_b    <= rounded + addend;
                r_step <= r_step + 1'b1;
            end
            S_FIN: begin
                if (out_free) begin
                    if (y_full > SAT_HI) begin
                        r_tap <= SAT_HI[SAMPLE_BITS-1:0];
                    end else if (y_full < SAT_LO) begin
                        r_tap <= SAT_LO[SAMPLE_BITS-1:0];
                    end else begin
                        r_tap <= y_full[SAMPLE_BITS-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_stat    = '{clearing: (r_state == S_CLEAR)};
    assign o_valid   = r_out_valid;
    assign o_tap_out = r_tap;

    // The write head always lies inside the active buffer length.
    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < i_cfg.buf_len)
        else $error("write head beyond buffer length");

    // Remainder results only arrive while the sequencer waits for them.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("remainder result outside a division state");

    // A new result is loaded only when the previous one has gone.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_tap)))
        else $error("pending result overwritten");

endmodule

### src/interpolating_loop_delay_line.sv
// ----------------------------------------------------------------------------
// interpolating_loop_delay_line
// Fractional delay line with loop window and linear or Catmull-Rom taps.
// ----------------------------------------------------------------------------
// After reset the sample store is cleared one entry a cycle; no transaction
// is taken during that time, but configuration writes are. Each transaction
// then passes through a two-entry queue and is carried out on its own: the
// delay is reduced by a bit-serial remainder unit (with a second pass in loop
// mode for the head position) and the four stencil samples are read one a
// cycle from the single-port store; Catmull-Rom takes extra multiply steps
// over linear interpolation, and a finished result waits in the back end
// while the output is stalled. Up to four transactions may be held (two
// queued, one in the back end and one result waiting on the output).
module interpolating_loop_delay_line (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic                                    i_record,
    input  logic signed [ildl_pkg::SAMPLE_BITS-1:0]  i_sample_in,
    input  logic [ildl_pkg::DELAY_BITS-1:0]          i_delay_whole,
    input  logic [ildl_pkg::FRAC_BITS-1:0]           i_delay_frac,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [ildl_pkg::SAMPLE_BITS-1:0]  o_tap_out,
    input  logic                                    i_cfg_we,
    input  logic [ildl_pkg::CFG_IDX_BITS-1:0]        i_cfg_idx,
    input  logic [ildl_pkg::LEN_BITS-1:0]            i_cfg_data
);
    import ildl_pkg::*;

    logic [LEN_BITS-1:0]  r_buf_len;
    logic                 r_interp;
    logic                 r_loop_en;
    logic [ADDR_BITS-1:0] r_win_begin;
    logic [ADDR_BITS-1:0] r_win_stop;
    t_cfg                 cfg;
    t_item                q_item;
    t_back_stat           stat;
    logic                 q_valid;
    logic                 q_pop;

    // Configuration registers; the buffer length is clamped on write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_len   <= LEN_BITS'(DEPTH);
            r_interp    <= 1'b1;
            r_loop_en   <= 1'b0;
            r_win_begin <= '0;
            r_win_stop  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BUF_LEN: begin
                    if (i_cfg_data < LEN_BITS'(MIN_LEN)) begin
                        r_buf_len <= LEN_BITS'(MIN_LEN);
                    end else if (i_cfg_data > LEN_BITS'(DEPTH)) begin
                        r_buf_len <= LEN_BITS'(DEPTH);
                    end else begin
                        r_buf_len <= i_cfg_data;
                    end
                end
                REG_INTERP:    r_interp    <= i_cfg_data[0];
                REG_LOOP_EN:   r_loop_en   <= i_cfg_data[0];
                REG_WIN_BEGIN: r_win_begin <= i_cfg_data[ADDR_BITS-1:0];
                REG_WIN_STOP:  r_win_stop  <= i_cfg_data[ADDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = '{buf_len: r_buf_len, interp: r_interp, loop_en: r_loop_en,
                   win_begin: r_win_begin, win_stop: r_win_stop,
                   head_clr: i_cfg_we && (i_cfg_idx == REG_BUF_LEN)};

    ildl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_record      (i_record),
        .i_sample_in   (i_sample_in),
        .i_delay_whole (i_delay_whole),
        .i_delay_frac  (i_delay_frac),
        .i_stat        (stat),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    ildl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_stat    (stat),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_tap_out (o_tap_out)
    );

endmodule
